// File: hw/rtl/assert_macros.svh
// Concurrent assertion shorthands; clk and rst_n are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fdl_pkg.sv
`timescale 1ns / 1ps

package fdl_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int DELAY_W    = 20;
    localparam int SIZE_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd12;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_READ  = 1'b1;

    // four taps, one read issued per cycle, then the read latency and the capture
    // of the last tap in the tap registers
    localparam logic [2:0] FETCH_LAST = 3'd5;
    // three Horner steps
    localparam logic [1:0] STEP_LAST  = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE    = 2'd0,
        MODE_LINEAR  = 2'd1,
        MODE_CUBIC   = 2'd2,
        MODE_HERMITE = 2'd3
    } interp_mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_CALC,
        ST_HOLD
    } fdl_state_t;

    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_MUL,
        CALC_ADD,
        CALC_FIN
    } calc_state_t;

    typedef struct packed {
        logic         start;
        interp_mode_t mode;
    } calc_ctl_t;

endpackage

// File: hw/rtl/fdl_mem.sv
`timescale 1ns / 1ps

module fdl_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/fdl_interp.sv
`timescale 1ns / 1ps

module fdl_interp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdl_pkg::calc_ctl_t            ctl,
    input  logic [fdl_pkg::FRAC_BITS-1:0] frac,
    input  logic signed [SAMPLE_BITS-1:0] xm1,
    input  logic signed [SAMPLE_BITS-1:0] x0,
    input  logic signed [SAMPLE_BITS-1:0] x1,
    input  logic signed [SAMPLE_BITS-1:0] x2,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] result
);

    // Hermite terms reach about 13 * 2^SAMPLE_BITS; keep headroom
    localparam int ACC_W  = SAMPLE_BITS + 6;
    localparam int PROD_W = ACC_W + fdl_pkg::FRAC_BITS + 1;

    fdl_pkg::calc_state_t state_reg, state_next;

    logic signed [ACC_W-1:0]  e_m1, e_0, e_1, e_2;
    logic signed [ACC_W-1:0]  a0, a1, a2, h1, h2, h3, d01;
    logic signed [ACC_W-1:0]  coef_in [4];
    logic signed [ACC_W-1:0]  t_reg, t_next;
    logic signed [ACC_W-1:0]  coef_reg [3];
    logic signed [PROD_W-1:0] p_reg, p_next;
    logic signed [PROD_W-1:0] p_round, p_shift;
    logic signed [ACC_W-1:0]  final_val;
    logic [1:0]               step_reg;
    fdl_pkg::interp_mode_t    mode_reg;
    logic [fdl_pkg::FRAC_BITS-1:0] frac_reg;

    // coefficients for a uniform three-step Horner evaluation
    always_comb
    begin
        e_m1 = {{(ACC_W-SAMPLE_BITS){xm1[SAMPLE_BITS-1]}}, xm1};
        e_0  = {{(ACC_W-SAMPLE_BITS){x0[SAMPLE_BITS-1]}}, x0};
        e_1  = {{(ACC_W-SAMPLE_BITS){x1[SAMPLE_BITS-1]}}, x1};
        e_2  = {{(ACC_W-SAMPLE_BITS){x2[SAMPLE_BITS-1]}}, x2};
        a0   = e_2 - e_1 - e_m1 + e_0;
        a1   = e_m1 - e_0 - a0;
        a2   = e_1 - e_m1;
        d01  = e_0 - e_1;
        h1   = e_1 - e_m1;
        h3   = (d01 <<< 1) + d01 + (e_2 - e_m1);
        h2   = ((e_m1 - e_0) <<< 1) + h1 - h3;
        unique case (ctl.mode)
            fdl_pkg::MODE_LINEAR:
            begin
                coef_in[0] = '0;
                coef_in[1] = '0;
                coef_in[2] = e_1 - e_0;
                coef_in[3] = e_0;
            end
            fdl_pkg::MODE_CUBIC:
            begin
                coef_in[0] = a0;
                coef_in[1] = a1;
                coef_in[2] = a2;
                coef_in[3] = e_0;
            end
            fdl_pkg::MODE_HERMITE:
            begin
                // held doubled; halved with rounding at the end
                coef_in[0] = h3;
                coef_in[1] = h2;
                coef_in[2] = h1;
                coef_in[3] = e_0 <<< 1;
            end
            default:
            begin
                coef_in[0] = '0;
                coef_in[1] = '0;
                coef_in[2] = '0;
                coef_in[3] = e_0;
            end
        endcase
    end

    always_comb
    begin
        p_next  = PROD_W'(t_reg) * PROD_W'($signed({1'b0, frac_reg}));
        p_round = p_reg + PROD_W'(fdl_pkg::ROUND_HALF);
        p_shift = p_round >>> fdl_pkg::FRAC_BITS;
        t_next  = ACC_W'(p_shift) + coef_reg[0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdl_pkg::CALC_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = fdl_pkg::CALC_MUL;
                end
            end
            fdl_pkg::CALC_MUL:
            begin
                state_next = fdl_pkg::CALC_ADD;
            end
            fdl_pkg::CALC_ADD:
            begin
                state_next = (step_reg == fdl_pkg::STEP_LAST) ? fdl_pkg::CALC_FIN
                                                              : fdl_pkg::CALC_MUL;
            end
            fdl_pkg::CALC_FIN:
            begin
                state_next = fdl_pkg::CALC_IDLE;
            end
            default:
            begin
                state_next = fdl_pkg::CALC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done = (state_reg == fdl_pkg::CALC_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdl_pkg::CALC_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fdl_pkg::CALC_IDLE && ctl.start)
            begin
                step_reg <= '0;
            end
            else if (state_reg == fdl_pkg::CALC_ADD)
            begin
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fdl_pkg::CALC_IDLE && ctl.start)
        begin
            t_reg       <= coef_in[0];
            coef_reg[0] <= coef_in[1];
            coef_reg[1] <= coef_in[2];
            coef_reg[2] <= coef_in[3];
            mode_reg    <= ctl.mode;
            frac_reg    <= frac;
        end
        else if (state_reg == fdl_pkg::CALC_MUL)
        begin
            p_reg <= p_next;
        end
        else if (state_reg == fdl_pkg::CALC_ADD)
        begin
            t_reg       <= t_next;
            coef_reg[0] <= coef_reg[1];
            coef_reg[1] <= coef_reg[2];
        end
    end

    // halve with rounding in Hermite mode, then saturate to the sample range
    always_comb
    begin
        if (mode_reg == fdl_pkg::MODE_HERMITE)
        begin
            final_val = (t_reg + ACC_W'(1)) >>> 1;
        end
        else
        begin
            final_val = t_reg;
        end
        if (final_val[ACC_W-1:SAMPLE_BITS-1] == '0 ||
            final_val[ACC_W-1:SAMPLE_BITS-1] == '1)
        begin
            result = final_val[SAMPLE_BITS-1:0];
        end
        else if (final_val[ACC_W-1])
        begin
            result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

// File: hw/rtl/fractional_delay_line.sv
`timescale 1ns / 1ps

// Circular sample delay line with interpolated reads. A write beat advances
// the write pointer and stores the sample in the same cycle, so writes run
// one per clock while the input is not stalled. A read beat fetches its four
// taps through the single read port of the sample memory (four reads, then the
// read latency and the capture of the last tap), then runs three Horner steps
// on one shared multiplier, each a multiply state and an add state, and
// saturates in a final state: a read holds the input until its result is
// loaded, whatever the interpolation mode. A finished result sits in an output
// register, so the next beat is taken while it waits; a second result that
// finishes while the first is still stalled holds the input until the register
// frees. After reset the memory is zeroed one entry per cycle with the input
// stalled; configuration writes are taken at any time.
module fractional_delay_line #(
    parameter int DEPTH       = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic signed [SAMPLE_BITS-1:0]  sample_in,
    input  logic [fdl_pkg::DELAY_W-1:0]    delay_amount,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_BITS-1:0]  sample_out,
    input  logic                           cfg_wr_en,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + fdl_pkg::FRAC_BITS;

    fdl_pkg::fdl_state_t state_reg, state_next;

    logic [fdl_pkg::SIZE_W-1:0] size_log2_reg;
    fdl_pkg::interp_mode_t      interp_mode_reg;

    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] wi_reg;
    logic [AW-1:0] base_reg;
    logic [fdl_pkg::FRAC_BITS-1:0] frac_reg;
    logic [2:0]    cnt_reg;
    logic signed [SAMPLE_BITS-1:0] tap_reg [4];
    logic          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic [AW-1:0] mask;
    logic [PW-1:0] pos;
    logic [AW-1:0] wr_addr;
    logic          in_accept;
    logic          out_free;
    logic          out_load;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_rdata;

    fdl_pkg::calc_ctl_t            calc_ctl;
    logic                          calc_done;
    logic signed [SAMPLE_BITS-1:0] calc_result;

    always_comb
    begin
        for (int i = 0; i < AW; i++)
        begin
            mask[i] = (i < int'(size_log2_reg));
        end
    end

    always_comb
    begin
        in_accept = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
        pos       = {wi_reg, {fdl_pkg::FRAC_BITS{1'b0}}} - PW'(delay_amount);
        wr_addr   = (wi_reg + AW'(1)) & mask;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdl_pkg::ST_CLEAR:
            begin
                if (&clr_addr_reg)
                begin
                    state_next = fdl_pkg::ST_IDLE;
                end
            end
            fdl_pkg::ST_IDLE:
            begin
                if (in_accept && action == fdl_pkg::ACTION_READ)
                begin
                    state_next = fdl_pkg::ST_FETCH;
                end
            end
            fdl_pkg::ST_FETCH:
            begin
                if (cnt_reg == fdl_pkg::FETCH_LAST)
                begin
                    state_next = fdl_pkg::ST_CALC;
                end
            end
            fdl_pkg::ST_CALC:
            begin
                if (calc_done)
                begin
                    state_next = out_free ? fdl_pkg::ST_IDLE : fdl_pkg::ST_HOLD;
                end
            end
            fdl_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = fdl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != fdl_pkg::ST_IDLE);
        calc_ctl.start = (state_reg == fdl_pkg::ST_FETCH) && (cnt_reg == fdl_pkg::FETCH_LAST);
        calc_ctl.mode  = interp_mode_reg;
        out_load       = out_free && ((state_reg == fdl_pkg::ST_CALC && calc_done) ||
                                      state_reg == fdl_pkg::ST_HOLD);
        // tap offsets -1, 0, 1, 2 from the base index
        mem_raddr      = (base_reg + AW'(cnt_reg) - AW'(1)) & mask;
        if (state_reg == fdl_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = in_accept && action == fdl_pkg::ACTION_WRITE;
            mem_waddr = wr_addr;
            mem_wdata = sample_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fdl_pkg::ST_CLEAR;
            size_log2_reg   <= fdl_pkg::SIZE_LOG2_RST;
            interp_mode_reg <= fdl_pkg::MODE_NONE;
            clr_addr_reg    <= '0;
            wi_reg          <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    fdl_pkg::REG_SIZE_LOG2:
                    begin
                        size_log2_reg <= cfg_data[fdl_pkg::SIZE_W-1:0];
                    end
                    fdl_pkg::REG_INTERP_MODE:
                    begin
                        interp_mode_reg <= fdl_pkg::interp_mode_t'(cfg_data[fdl_pkg::MODE_W-1:0]);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == fdl_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (in_accept && action == fdl_pkg::ACTION_WRITE)
            begin
                wi_reg <= wi_reg + AW'(1);
            end
            if (state_reg == fdl_pkg::ST_FETCH)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && action == fdl_pkg::ACTION_READ)
        begin
            base_reg <= pos[PW-1:fdl_pkg::FRAC_BITS];
            frac_reg <= pos[fdl_pkg::FRAC_BITS-1:0];
        end
        // read data comes from the memory's registered output, so the first fetch step captures nothing
        if (state_reg == fdl_pkg::ST_FETCH && cnt_reg != '0)
        begin
            tap_reg[0] <= tap_reg[1];
            tap_reg[1] <= tap_reg[2];
            tap_reg[2] <= tap_reg[3];
            tap_reg[3] <= mem_rdata;
        end
        if (out_load)
        begin
            sample_out_reg <= calc_result;
        end
    end

    fdl_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fdl_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (calc_ctl),
        .frac   (frac_reg),
        .xm1    (tap_reg[0]),
        .x0     (tap_reg[1]),
        .x1     (tap_reg[2]),
        .x2     (tap_reg[3]),
        .done   (calc_done),
        .result (calc_result)
    );

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

// File: hw/rtl/fdl_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdl_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   action,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] sample_out
);

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out), "stalled result beat changed")
    `ASSERT_NEXT(a_read_busy, in_valid && !in_stall && action == fdl_pkg::ACTION_READ, in_stall, "input not held after read beat")
    `ASSERT_NEXT(a_write_silent, in_valid && !in_stall && action == fdl_pkg::ACTION_WRITE && !out_valid, !out_valid, "write beat produced a result")
    `ASSERT_IMPLIES(a_result_busy, $rose(out_valid), $past(in_stall), "result appeared without a read in progress")

endmodule

bind fractional_delay_line fdl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fdl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);

// File: test/fractional_delay_line_test.sv
`timescale 1ns / 1ps

module fractional_delay_line_test;

    localparam int STORE_DEPTH = 4096;
    localparam int QUIET_LIMIT = 12000;
    localparam int RANDOM_PHASES = 14;
    localparam int BEATS_PER_PHASE = 125;

    typedef struct {
        logic                        act;
        logic signed [23:0]          smp;
        logic [fdl_pkg::DELAY_W-1:0] dly;
    } line_beat_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             action = fdl_pkg::ACTION_WRITE;
    logic signed [23:0]               sample_in = '0;
    logic [fdl_pkg::DELAY_W-1:0]      delay_amount = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic signed [23:0]               sample_out;
    logic                             cfg_wr_en = 1'b0;
    logic [fdl_pkg::CFG_IDX_W-1:0]    cfg_index = fdl_pkg::REG_SIZE_LOG2;
    logic [fdl_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    // shadow copy of the line
    logic signed [23:0]               shadow_store [STORE_DEPTH];
    logic [11:0]                      shadow_wr_ptr = '0;
    logic [fdl_pkg::SIZE_W-1:0]       shadow_size = fdl_pkg::SIZE_LOG2_RST;
    fdl_pkg::interp_mode_t            shadow_mode = fdl_pkg::MODE_NONE;

    line_beat_t              queued_beats [$];
    logic signed [23:0]      expected_samples [$];
    line_beat_t              next_beat;
    logic [2:0]              send_wait = '0;
    logic [2:0]              stall_left = '0;
    int                      stall_draw;
    logic signed [23:0]      want;
    logic                    sender_idles = 1'b0;
    logic                    receiver_idles = 1'b0;
    int                      mismatch_count = 0;
    int                      quiet_cycles = 0;

    fractional_delay_line dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .sample_in    (sample_in),
        .delay_amount (delay_amount),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(logic idles);
        return idles ? $urandom_range(0, 7) : 0;
    endfunction

    function automatic logic [11:0] size_mask();
        logic [16:0] m;
        m = (17'd1 << shadow_size) - 17'd1;
        return m[11:0];
    endfunction

    // round half up, drop the fraction bits
    function automatic longint round_frac(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [23:0] predict_read(logic [fdl_pkg::DELAY_W-1:0] dly);
        logic [fdl_pkg::DELAY_W-1:0] pos;
        logic [11:0]                 mask;
        logic [11:0]                 base;
        longint                      xm1, x0, x1, x2, f, t, c1, c2, c3, r;
        mask = size_mask();
        pos  = {shadow_wr_ptr, 8'h00} - dly;
        base = pos[fdl_pkg::DELAY_W-1:fdl_pkg::FRAC_BITS];
        f    = pos[fdl_pkg::FRAC_BITS-1:0];
        xm1  = shadow_store[(base - 12'd1) & mask];
        x0   = shadow_store[base & mask];
        x1   = shadow_store[(base + 12'd1) & mask];
        x2   = shadow_store[(base + 12'd2) & mask];
        case (shadow_mode)
            fdl_pkg::MODE_LINEAR:
                r = x0 + round_frac((x1 - x0) * f, fdl_pkg::FRAC_BITS);
            fdl_pkg::MODE_CUBIC:
            begin
                c3 = x2 - x1 - xm1 + x0;
                c2 = xm1 - x0 - c3;
                c1 = x1 - xm1;
                t  = round_frac(c3 * f, fdl_pkg::FRAC_BITS) + c2;
                t  = round_frac(t * f, fdl_pkg::FRAC_BITS) + c1;
                r  = round_frac(t * f, fdl_pkg::FRAC_BITS) + x0;
            end
            fdl_pkg::MODE_HERMITE:
            begin
                // carried at twice the value, halved at the end
                c1 = x1 - xm1;
                c3 = 3 * (x0 - x1) + (x2 - xm1);
                c2 = 2 * (xm1 - x0) + c1 - c3;
                t  = round_frac(c3 * f, fdl_pkg::FRAC_BITS) + c2;
                t  = round_frac(t * f, fdl_pkg::FRAC_BITS) + c1;
                t  = round_frac(t * f, fdl_pkg::FRAC_BITS) + 2 * x0;
                r  = round_frac(t, 1);
            end
            default:
                r = x0;
        endcase
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        if (r < -64'sd8388608)
            r = -64'sd8388608;
        return 24'(r);
    endfunction

    function automatic logic signed [23:0] draw_sample();
        logic signed [23:0] v;
        case ($urandom_range(0, 7))
            0: v = 24'sh7FFFFF;
            1: v = 24'sh800000;
            2: v = 24'($urandom_range(0, 16)) - 24'sd8;
            default: v = 24'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [fdl_pkg::DELAY_W-1:0] draw_delay();
        int unsigned span;
        int unsigned lim;
        span = (shadow_size > 4'd12) ? STORE_DEPTH : (1 << shadow_size);
        case ($urandom_range(0, 9))
            0: return fdl_pkg::DELAY_W'($urandom());
            1: return {12'($urandom_range(0, span + 2)), 8'h00};
            2, 3, 4: lim = ((span < 16 ? span : 16) + 2) * 256 - 1;
            default: lim = (span + 3) * 256 - 1;
        endcase
        if (lim > 20'hFFFFF)
            lim = 20'hFFFFF;
        return fdl_pkg::DELAY_W'($urandom_range(0, lim));
    endfunction

    task automatic push_write(logic signed [23:0] smp);
        line_beat_t b;
        b.act = fdl_pkg::ACTION_WRITE;
        b.smp = smp;
        b.dly = fdl_pkg::DELAY_W'($urandom());
        queued_beats.push_back(b);
    endtask

    task automatic push_read(logic [fdl_pkg::DELAY_W-1:0] dly);
        line_beat_t b;
        b.act = fdl_pkg::ACTION_READ;
        b.smp = 24'($urandom());
        b.dly = dly;
        queued_beats.push_back(b);
    endtask

    // hold until every beat is in and every sample is out, then let the block settle
    task automatic drain_line();
        do
            @(negedge clk);
        while (queued_beats.size() != 0 || in_valid || expected_samples.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_config(logic [fdl_pkg::SIZE_W-1:0] lg, fdl_pkg::interp_mode_t mode);
        drain_line();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= fdl_pkg::REG_SIZE_LOG2;
        cfg_data  <= fdl_pkg::CFG_DATA_W'(lg);
        @(posedge clk);
        cfg_index <= fdl_pkg::REG_INTERP_MODE;
        cfg_data  <= fdl_pkg::CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_size = lg;
        shadow_mode = mode;
    endtask

    // driver: present queued beats, update the shadow line on each accepted write beat and predict each accepted read
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_wait <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (action == fdl_pkg::ACTION_WRITE)
                begin
                    shadow_wr_ptr = shadow_wr_ptr + 12'd1;
                    shadow_store[shadow_wr_ptr & size_mask()] = sample_in;
                end
                else
                    expected_samples.push_back(predict_read(delay_amount));
            end
            if (!in_valid || !in_stall)
            begin
                if (send_wait != 0)
                begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 3'd1;
                end
                else if (queued_beats.size() != 0)
                begin
                    next_beat = queued_beats.pop_front();
                    in_valid     <= 1'b1;
                    action       <= next_beat.act;
                    sample_in    <= next_beat.smp;
                    delay_amount <= next_beat.dly;
                    send_wait    <= 3'(draw_wait(sender_idles));
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each sample read back, stall before some of them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: sample_out expected none, got %0d", $time, sample_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                begin
                    $display("%0t: sample_out expected %0d, got %0d", $time, want, sample_out);
                    mismatch_count++;
                end
            end
            stall_draw = draw_wait(receiver_idles);
            stall_left <= 3'(stall_draw);
            out_stall  <= (stall_draw != 0);
        end
        else if (out_valid)
        begin
            stall_left <= stall_left - 3'd1;
            out_stall  <= (stall_left > 3'd1);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [fdl_pkg::SIZE_W-1:0] lg;
        foreach (shadow_store[i])
            shadow_store[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: nearest tap only, full buffer
        push_read(20'h00000);
        push_write(24'sh7FFFFF);
        push_write(24'sh800000);
        push_write(24'sh7FFFFF);
        push_write(24'sh800000);
        push_write(24'sd0);
        push_write(-24'sd1);
        push_read(20'h00000);
        push_read(20'h00180);
        push_read(20'hFFFFF);
        push_read(20'h000FF);

        set_config(4'd12, fdl_pkg::MODE_LINEAR);
        push_read(20'h00080);
        push_read(20'h0017F);
        push_read(20'h00280);

        // alternating full-scale taps push the curves past the rails
        set_config(4'd12, fdl_pkg::MODE_CUBIC);
        push_read(20'h00380);
        push_read(20'h00240);

        set_config(4'd12, fdl_pkg::MODE_HERMITE);
        push_read(20'h00380);
        push_read(20'h002C0);

        // zero size collapses every tap onto entry 0
        set_config(4'd0, fdl_pkg::MODE_HERMITE);
        push_write(24'sd5);
        push_read(20'h00080);

        set_config(4'd15, fdl_pkg::MODE_CUBIC);
        push_read(20'hFFFFF);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: lg = 4'd0;
                1: lg = 4'd1;
                2: lg = 4'd12;
                3: lg = 4'd15;
                default: lg = 4'($urandom_range(1, 13));
            endcase
            set_config(lg, fdl_pkg::interp_mode_t'(ph % 4));
            sender_idles   = (ph != 0) && ($urandom_range(0, 3) != 0);
            receiver_idles = (ph != 0) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_write(draw_sample());
                else
                    push_read(draw_delay());
            end
        end

        drain_line();
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
